// File: rtl/stq_pkg.sv
// Shared types and codes for the sorted expiry timer queue.
// No dependencies; used by stq_cell and sorted_expiry_timer_queue.
package stq_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int ID_W      = 10;
    localparam int TIME_W    = 32;
    localparam int OCC_W     = 7;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_ADJUST = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_DUPLICATE = 3'd3,
        STAT_EXPIRED   = 3'd4,
        STAT_NONE      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CELL_IDLE,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_POP
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REINSERT
    } t_state;

    // Contents of one slot as seen by its neighbors.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   conn_id;
        logic [TIME_W-1:0] expiry;
    } t_slot;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op          op;
        logic [ID_W-1:0]   conn_id;
        logic [TIME_W-1:0] expiry;
    } t_cell_cmd;

endpackage

// File: rtl/stq_cell.sv
// One slot of the sorted timer chain: holds one timer, shifts to/from neighbors.
// Depends on stq_pkg.
module stq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stq_pkg::t_cell_cmd i_cmd,
    input  stq_pkg::t_slot     i_left,
    input  stq_pkg::t_slot     i_right,
    input  logic               i_found,
    input  logic               i_keep,
    output stq_pkg::t_slot     o_slot,
    output logic               o_found,
    output logic               o_keep
);

    logic                       r_valid;
    logic [stq_pkg::ID_W-1:0]   r_id;
    logic [stq_pkg::TIME_W-1:0] r_expiry;
    logic                       n_valid;
    logic [stq_pkg::ID_W-1:0]   n_id;
    logic [stq_pkg::TIME_W-1:0] n_expiry;
    logic                       my_match;

    assign my_match = r_valid && (r_id == i_cmd.conn_id);
    assign o_found  = i_found | my_match;
    // this slot stays put on insert: its expiry is at or before the new one
    assign o_keep   = r_valid && (r_expiry <= i_cmd.expiry);

    assign o_slot.valid   = r_valid;
    assign o_slot.conn_id = r_id;
    assign o_slot.expiry  = r_expiry;

    always_comb begin
        n_valid  = r_valid;
        n_id     = r_id;
        n_expiry = r_expiry;
        unique case (i_cmd.op)
            stq_pkg::CELL_IDLE: begin
            end
            stq_pkg::CELL_INSERT: begin
                if (!o_keep) begin
                    if (i_keep) begin
                        n_valid  = 1'b1;
                        n_id     = i_cmd.conn_id;
                        n_expiry = i_cmd.expiry;
                    end else begin
                        n_valid  = i_left.valid;
                        n_id     = i_left.conn_id;
                        n_expiry = i_left.expiry;
                    end
                end
            end
            stq_pkg::CELL_REMOVE: begin
                if (o_found) begin
                    n_valid  = i_right.valid;
                    n_id     = i_right.conn_id;
                    n_expiry = i_right.expiry;
                end
            end
            stq_pkg::CELL_POP: begin
                n_valid  = i_right.valid;
                n_id     = i_right.conn_id;
                n_expiry = i_right.expiry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_expiry <= n_expiry;
    end

endmodule

// File: rtl/sorted_expiry_timer_queue.sv
// Add and delete go from the command registers through EXEC to the output register;
// an adjust that finds its timer also passes REINSERT. A tick gives one result
// per cycle while the output is not stalled. The single command slot ahead of the cell
// chain takes no new item until the sequencer is idle; a draining tick holds it.
// Reset (synchronous, active low) empties the queue at once; no clearing pass.
//
// Top level: command sequencer, chain of stq_cell slots and output register.
// Depends on stq_pkg and stq_cell.
module sorted_expiry_timer_queue #(
    parameter int SLOTS = stq_pkg::SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_action,
    input  logic [stq_pkg::ID_W-1:0]   i_conn_id,
    input  logic [stq_pkg::TIME_W-1:0] i_expire_time,
    input  logic [stq_pkg::TIME_W-1:0] i_now_time,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [2:0]                 o_status,
    output logic [stq_pkg::ID_W-1:0]   o_expired_id,
    output logic                       o_last,
    output logic [stq_pkg::OCC_W-1:0]  o_occupancy
);

    localparam int CNT_W = $clog2(SLOTS + 1);

    // Captured command
    stq_pkg::t_action           r_action;
    logic [stq_pkg::ID_W-1:0]   r_id;
    logic [stq_pkg::TIME_W-1:0] r_expire;
    logic [stq_pkg::TIME_W-1:0] r_now;

    stq_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    // Output register
    logic                       r_out_valid;
    stq_pkg::t_status           r_status;
    logic [stq_pkg::ID_W-1:0]   r_eid;
    logic                       r_last;
    logic [stq_pkg::OCC_W-1:0]  r_occ;

    logic                       push;
    stq_pkg::t_status           n_status;
    logic [stq_pkg::ID_W-1:0]   n_eid;
    logic                       n_last;

    logic                       in_xfer;
    logic                       out_free;
    logic                       full;
    logic                       found;
    logic                       head_due;
    logic                       next_due;

    // Cell chain wiring
    stq_pkg::t_cell_op  cell_op;
    stq_pkg::t_cell_cmd cmd;
    stq_pkg::t_slot     slot [SLOTS];
    stq_pkg::t_slot     left_in [SLOTS];
    stq_pkg::t_slot     right_in [SLOTS];
    logic [SLOTS:0]     found_ch;
    logic [SLOTS:0]     keep_ch;
    logic [SLOTS-1:0]   valid_vec;

    // The sequencer takes one item at a time; stall while it is busy.
    assign o_stall  = (r_state != stq_pkg::ST_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    // A result may be written when the output register is empty or draining.
    assign out_free = !r_out_valid || !i_stall;
    assign full     = (r_count == CNT_W'(SLOTS));

    assign cmd.op      = cell_op;
    assign cmd.conn_id = r_id;
    assign cmd.expiry  = r_expire;

    // Match chain starts clear; the keep chain starts set so that slot 0
    // takes a new timer whenever it does not hold an earlier one itself.
    assign found_ch[0] = 1'b0;
    assign keep_ch[0]  = 1'b1;
    assign found       = found_ch[SLOTS];

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign left_in[g] = '0;
            end else begin : g_inner_l
                assign left_in[g] = slot[g-1];
            end
            if (g == SLOTS - 1) begin : g_last
                assign right_in[g] = '0;
            end else begin : g_inner_r
                assign right_in[g] = slot[g+1];
            end
            assign valid_vec[g] = slot[g].valid;

            stq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (cmd),
                .i_left  (left_in[g]),
                .i_right (right_in[g]),
                .i_found (found_ch[g]),
                .i_keep  (keep_ch[g]),
                .o_slot  (slot[g]),
                .o_found (found_ch[g+1]),
                .o_keep  (keep_ch[g+1])
            );
        end
    endgenerate

    // Head of the queue and the entry behind it decide the tick loop.
    assign head_due = slot[0].valid && (slot[0].expiry <= r_now);
    assign next_due = slot[1].valid && (slot[1].expiry <= r_now);

    // Capture the command on each input transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action <= stq_pkg::t_action'(i_action);
            r_id     <= i_conn_id;
            r_expire <= i_expire_time;
            r_now    <= i_now_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stq_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= push | (r_out_valid & i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_status <= n_status;
            r_eid    <= n_eid;
            r_last   <= n_last;
            r_occ    <= stq_pkg::OCC_W'(n_count);
        end
    end

    // Sequencer: pick the chain operation and the result for this cycle.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        cell_op  = stq_pkg::CELL_IDLE;
        push     = 1'b0;
        n_status = stq_pkg::STAT_OK;
        n_eid    = '0;
        n_last   = 1'b1;
        unique case (r_state)
            stq_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = stq_pkg::ST_EXEC;
                end
            end
            stq_pkg::ST_EXEC: begin
                unique case (r_action)
                    stq_pkg::ACT_ADD: begin
                        if (out_free) begin
                            push    = 1'b1;
                            n_state = stq_pkg::ST_IDLE;
                            priority if (found) begin
                                n_status = stq_pkg::STAT_DUPLICATE;
                            end else if (full) begin
                                n_status = stq_pkg::STAT_FULL;
                            end else begin
                                cell_op = stq_pkg::CELL_INSERT;
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                    stq_pkg::ACT_ADJUST: begin
                        // Take the timer out now, place it again in REINSERT.
                        if (found) begin
                            cell_op = stq_pkg::CELL_REMOVE;
                            n_count = r_count - 1'b1;
                            n_state = stq_pkg::ST_REINSERT;
                        end else if (out_free) begin
                            push     = 1'b1;
                            n_status = stq_pkg::STAT_NOT_FOUND;
                            n_state  = stq_pkg::ST_IDLE;
                        end
                    end
                    stq_pkg::ACT_DELETE: begin
                        if (out_free) begin
                            push    = 1'b1;
                            n_state = stq_pkg::ST_IDLE;
                            if (found) begin
                                cell_op = stq_pkg::CELL_REMOVE;
                                n_count = r_count - 1'b1;
                            end else begin
                                n_status = stq_pkg::STAT_NOT_FOUND;
                            end
                        end
                    end
                    stq_pkg::ACT_TICK: begin
                        // Drain due timers from the head, one per cycle while the output is free.
                        if (out_free) begin
                            push = 1'b1;
                            if (head_due) begin
                                cell_op  = stq_pkg::CELL_POP;
                                n_count  = r_count - 1'b1;
                                n_status = stq_pkg::STAT_EXPIRED;
                                n_eid    = slot[0].conn_id;
                                n_last   = !next_due;
                                if (!next_due) begin
                                    n_state = stq_pkg::ST_IDLE;
                                end
                            end else begin
                                n_status = stq_pkg::STAT_NONE;
                                n_state  = stq_pkg::ST_IDLE;
                            end
                        end
                    end
                endcase
            end
            stq_pkg::ST_REINSERT: begin
                if (out_free) begin
                    cell_op = stq_pkg::CELL_INSERT;
                    n_count = r_count + 1'b1;
                    push    = 1'b1;
                    n_state = stq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_expired_id = r_eid;
    assign o_last       = r_last;
    assign o_occupancy  = r_occ;

    // The occupancy counter matches the live slots in the chain.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == r_count)
        else $error("timer count differs from live slots");

    // Live slots stay packed at the head of the chain.
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, valid_vec} + {{SLOTS{1'b0}}, 1'b1}))
        else $error("live slots not packed");

    // A non-final expired result keeps the tick loop running.
    a_tick_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !n_last) |=> (r_state == stq_pkg::ST_EXEC))
        else $error("tick loop ended early");

    // A move into REINSERT comes only from an adjust and leaves room for the insert.
    a_reinsert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stq_pkg::ST_EXEC && n_state == stq_pkg::ST_REINSERT)
        |=> (r_action == stq_pkg::ACT_ADJUST && !full))
        else $error("reinsert without room");

endmodule
